### sv/frac_pkg.sv
package frac_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_RED = 3'd4;

    typedef struct packed {
        logic [2:0]                    command;
        logic signed [DATA_WIDTH-1:0]  num_a;
        logic signed [DATA_WIDTH-1:0]  den_a;
        logic signed [DATA_WIDTH-1:0]  num_b;
        logic signed [DATA_WIDTH-1:0]  den_b;
    } frac_req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  num_out;
        logic signed [DATA_WIDTH-1:0]  den_out;
    } frac_rsp_t;

endpackage

### sv/fraction_alu_with_reduction_core.sv
// Fraction ALU: add, subtract, multiply and divide form unreduced cross products
// (low DATA_WIDTH bits, two's complement) through one registered multiplier used
// three times in S_MUL, then S_FIN writes the arithmetic result to the output register.
// Reduce runs a binary gcd on the magnitudes, one shift or compare/subtract per
// cycle, then a restoring divide over all DATA_WIDTH quotient bits that forms both
// quotients side by side. A zero part or an unused command code skips straight to
// the result. One item is in flight at a time; req_stall is high while it is
// worked on. The result sits in an output register, so a new item may be taken
// while the last result waits.
module fraction_alu_with_reduction_core
    import frac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  frac_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output frac_rsp_t rsp_data
);

    localparam int W = DATA_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_GCD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    function automatic word_t mag(input word_t v);
        mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // control
    logic [2:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // datapath
    logic [2:0]       cmd_reg, cmd_next;
    word_t            na_reg, na_next, da_reg, da_next;
    word_t            nb_reg, nb_next, db_reg, db_next;
    word_t            p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    word_t            x_reg, x_next, y_reg, y_next;
    logic [CNT_W-1:0] k_reg, k_next, cnt_reg, cnt_next;
    word_t            g_reg, g_next;
    word_t            qa_reg, qa_next, qb_reg, qb_next;
    word_t            ra_reg, ra_next, rb_reg, rb_next;
    frac_rsp_t        rsp_reg, rsp_next;

    logic             accept;
    word_t            mul_a, mul_b;
    logic [2*W-1:0]   mul_full;
    logic [W:0]       xy_diff;
    logic [W:0]       ra_sh, rb_sh;
    logic [W+1:0]     ta, tb;
    logic             out_free;
    logic             red_zero;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign red_zero  = (na_reg == '0) || (da_reg == '0);

    // shared multiplier: step 0 na*db (na*nb for multiply), step 1 da*nb, step 2 da*db
    always_comb
    begin
        mul_a = (step_reg == 2'd0) ? na_reg : da_reg;
        if (step_reg == 2'd0)
        begin
            mul_b = (cmd_reg == CMD_MUL) ? nb_reg : db_reg;
        end
        else if (step_reg == 2'd1)
        begin
            mul_b = nb_reg;
        end
        else
        begin
            mul_b = db_reg;
        end
    end

    assign mul_full = mul_a * mul_b;
    assign xy_diff  = {1'b0, x_reg} - {1'b0, y_reg};

    // restoring divide lanes, one quotient bit per cycle each
    assign ra_sh = {ra_reg, qa_reg[W-1]};
    assign rb_sh = {rb_reg, qb_reg[W-1]};
    assign ta    = {1'b0, ra_sh} - {2'b00, g_reg};
    assign tb    = {1'b0, rb_sh} - {2'b00, g_reg};

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd_next       = cmd_reg;
        na_next        = na_reg;
        da_next        = da_reg;
        nb_next        = nb_reg;
        db_next        = db_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        g_next         = g_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = req_data.command;
                    na_next   = req_data.num_a;
                    da_next   = req_data.den_a;
                    nb_next   = req_data.num_b;
                    db_next   = req_data.den_b;
                    step_next = 2'd0;
                    x_next    = mag(req_data.num_a);
                    y_next    = mag(req_data.den_a);
                    k_next    = '0;
                    case (req_data.command) inside
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: state_next = S_MUL;
                        CMD_RED:
                        begin
                            if (req_data.num_a == '0 || req_data.den_a == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_GCD;
                            end
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end

            S_MUL:
            begin
                if (step_reg == 2'd0)
                begin
                    p0_next = mul_full[W-1:0];
                end
                else if (step_reg == 2'd1)
                begin
                    p1_next = mul_full[W-1:0];
                end
                else
                begin
                    p2_next = mul_full[W-1:0];
                end
                if (step_reg == 2'd2)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end

            S_GCD:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (xy_diff == '0)
                begin
                    g_next     = x_reg << k_reg;
                    qa_next    = mag(na_reg);
                    qb_next    = mag(da_reg);
                    ra_next    = '0;
                    rb_next    = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = S_DIV;
                end
                else if (!xy_diff[W])
                begin
                    x_next = xy_diff[W-1:0];
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end

            S_DIV:
            begin
                if (!ta[W+1])
                begin
                    ra_next = ta[W-1:0];
                end
                else
                begin
                    ra_next = ra_sh[W-1:0];
                end
                if (!tb[W+1])
                begin
                    rb_next = tb[W-1:0];
                end
                else
                begin
                    rb_next = rb_sh[W-1:0];
                end
                qa_next = {qa_reg[W-2:0], !ta[W+1]};
                qb_next = {qb_reg[W-2:0], !tb[W+1]};
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            rsp_next.num_out = p0_reg + p1_reg;
                            rsp_next.den_out = p2_reg;
                        end
                        CMD_SUB:
                        begin
                            rsp_next.num_out = p0_reg - p1_reg;
                            rsp_next.den_out = p2_reg;
                        end
                        CMD_MUL:
                        begin
                            rsp_next.num_out = p0_reg;
                            rsp_next.den_out = p2_reg;
                        end
                        CMD_DIV:
                        begin
                            rsp_next.num_out = p0_reg;
                            rsp_next.den_out = p1_reg;
                        end
                        CMD_RED:
                        begin
                            if (red_zero)
                            begin
                                rsp_next.num_out = na_reg;
                                rsp_next.den_out = da_reg;
                            end
                            else
                            begin
                                // sign restored on the exact quotient, wrapped
                                rsp_next.num_out = na_reg[W-1] ? (~qa_reg + 1'b1) : qa_reg;
                                rsp_next.den_out = da_reg[W-1] ? (~qb_reg + 1'b1) : qb_reg;
                            end
                        end
                        default:
                        begin
                            rsp_next.num_out = '0;
                            rsp_next.den_out = '0;
                        end
                    endcase
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        na_reg  <= na_next;
        da_reg  <= da_next;
        nb_reg  <= nb_next;
        db_reg  <= db_next;
        p0_reg  <= p0_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
        g_reg   <= g_next;
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        rsp_reg <= rsp_next;
    end

    // gcd operands never reach zero, or the loop would not end
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (x_reg != '0) && (y_reg != '0))
        else $error("gcd operand went to zero");

    // the gcd divides both magnitudes exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && ($past(state_reg) == S_DIV) |->
            (ra_reg == '0) && (rb_reg == '0))
        else $error("reduce left a nonzero remainder");

    // a finished item with a free output register is delivered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_free |=> rsp_valid && (state_reg == S_IDLE))
        else $error("finished result not delivered");

endmodule

### verif/tb_fraction_alu_with_reduction_core.sv
module tb_fraction_alu_with_reduction_core
    import frac_pkg::*;
();

    // command codes the block leaves unused; they must come back as 0/0
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 900;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        frac_req_t req;
        logic      typed;
        frac_rsp_t want;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    frac_req_t req_data = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    frac_rsp_t rsp_data;

    frac_rsp_t   pending_results[$];
    int unsigned fail_count = 0;
    int unsigned transfers_in = 0;
    int unsigned reduce_count = 0;
    int unsigned unused_count = 0;
    int unsigned results_checked = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // typed rows: expected result fixed in the table; others go through the predictor
    directed_row_t directed_rows [N_DIRECTED] = '{
        {CMD_ADD, 32'h1, 32'h2, 32'h1, 32'h3, 1'b1, 32'h5, 32'h6},
        {CMD_SUB, 32'h1, 32'h2, 32'h1, 32'h3, 1'b1, 32'h1, 32'h6},
        {CMD_MUL, 32'h2, 32'h3, 32'h3, 32'h4, 1'b1, 32'h6, 32'hc},
        {CMD_DIV, 32'h2, 32'h3, 32'h3, 32'h4, 1'b1, 32'h8, 32'h9},
        {CMD_RED, 32'h6, 32'h8, 32'h0, 32'h0, 1'b1, 32'h3, 32'h4},
        {CMD_RED, 32'h0, 32'h5, 32'h9, 32'h9, 1'b1, 32'h0, 32'h5},
        {CMD_RED, 32'h7, 32'h0, 32'h9, 32'h9, 1'b1, 32'h7, 32'h0},
        {CMD_RED, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0},
        {CMD_RED, 32'h80000000, 32'h80000000, 32'h0, 32'h0,
         1'b1, 32'hffffffff, 32'hffffffff},
        {CMD_RED, 32'h80000000, 32'h1, 32'h0, 32'h0, 1'b1, 32'h80000000, 32'h1},
        {CMD_RED, 32'h80000000, 32'h40000000, 32'h0, 32'h0, 1'b1, 32'hfffffffe, 32'h1},
        {CMD_RED, 32'hfffffffa, 32'h4, 32'h0, 32'h0, 1'b1, 32'hfffffffd, 32'h2},
        {CMD_RED, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0, 1'b1, 32'h1, 32'h1},
        {CMD_RED, 32'h6, 32'hfffffffc, 32'h0, 32'h0, 1'b1, 32'h3, 32'hfffffffe},
        {CMD_RED, 32'h7ffffffe, 32'h3fffffff, 32'h0, 32'h0, 1'b1, 32'h2, 32'h1},
        {CMD_RED, 32'h4, 32'h6, 32'hffffffff, 32'hffffffff, 1'b1, 32'h2, 32'h3},
        {CMD_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         1'b0, 32'h0, 32'h0},
        {CMD_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
         1'b1, 32'h0, 32'h0},
        {CMD_SUB, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         1'b1, 32'h0, 32'h1},
        {CMD_DIV, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
         1'b0, 32'h0, 32'h0},
        {CMD_RSVD5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
         1'b1, 32'h0, 32'h0},
        {CMD_RSVD6, 32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 32'h87654321,
         1'b1, 32'h0, 32'h0},
        {CMD_RSVD7, 32'h80000000, 32'h7fffffff, 32'h1, 32'h0, 1'b1, 32'h0, 32'h0},
        {CMD_RED, 32'h12345678, 32'h9abcdef0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0},
        {CMD_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0}
    };

    fraction_alu_with_reduction_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #2 clk = ~clk;

    // magnitude one bit wider than the word, so the most negative value is exact
    function automatic logic [DATA_WIDTH:0] wide_magnitude(input word_t v);
        return v[DATA_WIDTH-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    endfunction

    function automatic word_t reduced_part(input word_t v, input logic [DATA_WIDTH:0] g);
        logic [DATA_WIDTH:0] q;
        q = wide_magnitude(v) / g;
        if (v[DATA_WIDTH-1])
            q = ~q + 1'b1;
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic frac_rsp_t predict_fraction(input frac_req_t rq);
        word_t               na, da, nb, db;
        logic [DATA_WIDTH:0] x, y, r;
        frac_rsp_t           res;
        na  = rq.num_a;
        da  = rq.den_a;
        nb  = rq.num_b;
        db  = rq.den_b;
        res = '0;
        case (rq.command)
            CMD_ADD:
            begin
                res.num_out = na * db + da * nb;
                res.den_out = da * db;
            end
            CMD_SUB:
            begin
                res.num_out = na * db - da * nb;
                res.den_out = da * db;
            end
            CMD_MUL:
            begin
                res.num_out = na * nb;
                res.den_out = da * db;
            end
            CMD_DIV:
            begin
                res.num_out = na * db;
                res.den_out = da * nb;
            end
            CMD_RED:
            begin
                if (na == '0 || da == '0)
                begin
                    res.num_out = na;
                    res.den_out = da;
                end
                else
                begin
                    x = wide_magnitude(na);
                    y = wide_magnitude(da);
                    while (y != '0)
                    begin
                        r = x % y;
                        x = y;
                        y = r;
                    end
                    res.num_out = reduced_part(na, x);
                    res.den_out = reduced_part(da, x);
                end
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    function automatic word_t random_operand();
        word_t v;
        case ($urandom_range(9))
            0, 1, 2: v = $urandom();
            3, 4:    v = word_t'($urandom_range(40)) - 32'd20;
            5:
            begin
                case ($urandom_range(4))
                    0:       v = 32'h80000000;
                    1:       v = 32'h7fffffff;
                    2:       v = 32'hffffffff;
                    3:       v = 32'h1;
                    default: v = 32'h0;
                endcase
            end
            6:       v = word_t'(1) << $urandom_range(DATA_WIDTH - 1);
            default: v = $urandom_range(4095);
        endcase
        if ($urandom_range(3) == 0)
            v = -v;
        return v;
    endfunction

    function automatic frac_req_t random_request();
        frac_req_t   rq;
        word_t       k;
        int unsigned pick;
        pick     = $urandom_range(99);
        rq.num_a = random_operand();
        rq.den_a = random_operand();
        rq.num_b = random_operand();
        rq.den_b = random_operand();
        if (pick < 8)
            rq.command = 3'($urandom_range(7, 5));
        else if (pick < 55)
            rq.command = 3'($urandom_range(3));
        else
        begin
            rq.command = CMD_RED;
            // most reductions share a real common factor
            if (pick < 92)
            begin
                k = (pick < 70) ? word_t'($urandom_range(1, 255))
                                : word_t'($urandom_range(1, 65535));
                rq.num_a = k * word_t'($urandom_range(1, 32767));
                rq.den_a = k * word_t'($urandom_range(1, 32767));
                if ($urandom_range(1))
                    rq.num_a = -rq.num_a;
                if ($urandom_range(1))
                    rq.den_a = -rq.den_a;
            end
        end
        return rq;
    endfunction

    // present one item and hold it until its transfer; idle gaps drop valid first
    task automatic drive_request(input frac_req_t item, input frac_rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_results.push_back(want);
        transfers_in++;
        if (item.command == CMD_RED)
            reduce_count++;
        else if (item.command > CMD_RED)
            unused_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        frac_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: num_out %h den_out %h",
                       rsp_data.num_out, rsp_data.den_out);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (rsp_data.num_out !== want.num_out)
                begin
                    $error("num_out: expected %h, got %h", want.num_out, rsp_data.num_out);
                    fail_count++;
                end
                if (rsp_data.den_out !== want.den_out)
                begin
                    $error("den_out: expected %h, got %h", want.den_out, rsp_data.den_out);
                    fail_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin : stimulus
        directed_row_t row;
        frac_req_t     rq;
        int unsigned   phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            drive_request(row.req, row.typed ? row.want : predict_fraction(row.req));
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            phase = (i * 4) / N_RANDOM;
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            rq = random_request();
            drive_request(rq, predict_fraction(rq));
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transfers (%0d reduce, %0d unused codes), %0d results compared",
                 transfers_in, reduce_count, unused_count, results_checked);
        $display("pacing: free flow, sparse sender, stalling receiver, both throttled");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
